// ===== rtl/core/rdan_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdan_pkg
// Shared widths and types for the reflect-about-normal pipeline.
// ----------------------------------------------------------------------------
package rdan_pkg;

  localparam int IN_W     = 16;               // input component width
  localparam int IN_FRAC  = 12;               // input fraction bits
  localparam int OUT_W    = 16;               // output component width
  localparam int OUT_FRAC = 14;               // output fraction bits
  localparam int DOT_W    = 2 * IN_W + 2;     // dot product, signed
  localparam int R_W      = DOT_W + IN_W;     // reflected vector, signed
  localparam int MAG_W    = R_W - 2;          // reflected magnitude
  localparam int CHUNK_W  = 16;               // leading-zero chunk width
  localparam int NORM_W   = 30;               // normalized magnitude width
  localparam int SQ_W     = 2 * NORM_W;       // one square
  localparam int SUM_W    = SQ_W + 2;         // sum of three squares
  localparam int ROOT_W   = SUM_W / 2;        // integer square root
  localparam int NUM_W    = NORM_W + OUT_FRAC + 1;  // divider numerator
  localparam int Q_W      = OUT_FRAC + 1;     // quotient width

  typedef struct packed {
    logic [2:0] neg;      // component sign of r
    logic       degen;    // r is the zero vector
  } rdan_tag_t;

  typedef struct packed {
    rdan_tag_t                  tag;
    logic [2:0][NORM_W-1:0]     a;   // block-normalized magnitudes
  } rdan_side_t;

endpackage

// ===== rtl/core/reflect_direction_about_normal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflect_direction_about_normal
// Reflects a direction about a surface normal and scales it to unit length.
// ----------------------------------------------------------------------------
// Each item carries a direction d and a normal n (signed Q3.12) and yields
// r = 2 (d.n) n - d normalized to unit length in signed Q1.14, rounded to
// nearest and held within +/-16384. A zero-length r gives zero components
// with degenerate set. The block is a fully pipelined datapath with no
// state between items: it takes one item every cycle while its output is
// not stalled. Eight stages form the dot product, reflection, block
// normalization and sum of squares, 31 stages resolve the square root one
// bit at a time, 16 stages form the rounded numerators and divide the
// three magnitudes by the length one quotient bit at a time, and the last
// stage saturates, applies signs and holds the result. The whole pipeline
// advances together whenever the output register is empty or being taken,
// so a stalled consumer holds every item in place and none is lost.
// ----------------------------------------------------------------------------
module reflect_direction_about_normal (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rdan_pkg::IN_W-1:0]  dir_x,
  input  logic signed [rdan_pkg::IN_W-1:0]  dir_y,
  input  logic signed [rdan_pkg::IN_W-1:0]  dir_z,
  input  logic signed [rdan_pkg::IN_W-1:0]  norm_x,
  input  logic signed [rdan_pkg::IN_W-1:0]  norm_y,
  input  logic signed [rdan_pkg::IN_W-1:0]  norm_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rdan_pkg::OUT_W-1:0] refl_x,
  output logic signed [rdan_pkg::OUT_W-1:0] refl_y,
  output logic signed [rdan_pkg::OUT_W-1:0] refl_z,
  output logic                              degenerate
);
  import rdan_pkg::*;

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << OUT_FRAC;

  logic                  en;
  logic                  sum_valid, root_valid, q_valid;
  logic [SUM_W-1:0]      sum;
  logic [ROOT_W-1:0]     root;
  rdan_side_t            sum_side, root_side;
  logic [2:0][Q_W-1:0]   q;
  rdan_tag_t             q_tag;
  logic signed [OUT_W-1:0] comp_next [3];

  // The pipeline moves as one; it halts only when a finished item waits.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  rdan_front u_front (
    .clk, .rst, .en, .in_valid,
    .dir_x, .dir_y, .dir_z, .norm_x, .norm_y, .norm_z,
    .sum_valid, .sum, .side(sum_side)
  );

  rdan_sqrt u_sqrt (
    .clk, .rst, .en, .sum_valid, .sum, .sum_side,
    .root_valid, .root, .root_side
  );

  rdan_div u_div (
    .clk, .rst, .en, .root_valid, .root, .root_side,
    .q_valid, .q, .q_tag
  );

  // Clamp to unit magnitude, restore the sign, and force zero when r was
  // the zero vector (the divider sees a zero length then).
  always_comb begin
    logic [Q_W-1:0] sat;
    for (int i = 0; i < 3; i++) begin
      sat = (q[i] > ONE) ? ONE : q[i];
      if (q_tag.degen) begin
        comp_next[i] = '0;
      end else if (q_tag.neg[i]) begin
        comp_next[i] = -OUT_W'(sat);
      end else begin
        comp_next[i] = OUT_W'(sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      refl_x     <= comp_next[0];
      refl_y     <= comp_next[1];
      refl_z     <= comp_next[2];
      degenerate <= q_tag.degen;
    end
  end

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> refl_x == '0 && refl_y == '0 && refl_z == '0)
    else $error("degenerate item with nonzero components");

  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> refl_x <= 16'sd16384 && refl_x >= -16'sd16384 &&
                  refl_y <= 16'sd16384 && refl_y >= -16'sd16384 &&
                  refl_z <= 16'sd16384 && refl_z >= -16'sd16384)
    else $error("component beyond unit magnitude");

  a_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> refl_x != '0 || refl_y != '0 || refl_z != '0)
    else $error("nondegenerate item came out as zero vector");

endmodule

// ===== rtl/core/rdan_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdan_front
// Dot product, reflection, magnitude, block normalization and sum of squares.
// ----------------------------------------------------------------------------
module rdan_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [rdan_pkg::IN_W-1:0]  dir_x,
  input  logic signed [rdan_pkg::IN_W-1:0]  dir_y,
  input  logic signed [rdan_pkg::IN_W-1:0]  dir_z,
  input  logic signed [rdan_pkg::IN_W-1:0]  norm_x,
  input  logic signed [rdan_pkg::IN_W-1:0]  norm_y,
  input  logic signed [rdan_pkg::IN_W-1:0]  norm_z,
  output logic                              sum_valid,
  output logic [rdan_pkg::SUM_W-1:0]        sum,
  output rdan_pkg::rdan_side_t              side
);
  import rdan_pkg::*;

  function automatic logic [4:0] lz16(input logic [CHUNK_W-1:0] x);
    logic [4:0] c;
    logic       hit;
    c   = 5'(CHUNK_W);
    hit = 1'b0;
    for (int b = CHUNK_W - 1; b >= 0; b--) begin
      if (!hit && x[b]) begin
        c   = 5'(CHUNK_W - 1 - b);
        hit = 1'b1;
      end
    end
    return c;
  endfunction

  logic signed [IN_W-1:0]   d0 [3];
  logic signed [IN_W-1:0]   n0 [3];

  logic                     v1, v2, v3, v4, v5, v6, v7;
  logic signed [IN_W-1:0]   d1 [3], n1 [3], d2 [3], n2 [3];
  logic signed [2*IN_W-1:0] p1 [3];
  logic signed [DOT_W-1:0]  dot2;
  logic signed [R_W-1:0]    r3 [3];
  logic [MAG_W-1:0]         mag4 [3], mag5 [3];
  logic [2:0]               neg4, neg5;
  logic [4:0]               lz5 [3];
  logic [2:0]               nz5;
  rdan_side_t               side6, side7;
  logic [SQ_W-1:0]          sq7 [3];

  logic [MAG_W-1:0]         mag_or;
  logic [5:0]               lz6;

  assign d0[0] = dir_x;
  assign d0[1] = dir_y;
  assign d0[2] = dir_z;
  assign n0[0] = norm_x;
  assign n0[1] = norm_y;
  assign n0[2] = norm_z;

  assign mag_or = mag4[0] | mag4[1] | mag4[2];

  always_comb begin
    if (nz5[2]) begin
      lz6 = 6'(lz5[2]);
    end else if (nz5[1]) begin
      lz6 = 6'(CHUNK_W) + 6'(lz5[1]);
    end else begin
      lz6 = 6'(2 * CHUNK_W) + 6'(lz5[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; sum_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; sum_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [R_W-1:0] prod;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // Products of the dot product.
        p1[i] <= d0[i] * n0[i];
        d1[i] <= d0[i];
        n1[i] <= n0[i];
        d2[i] <= d1[i];
        n2[i] <= n1[i];
        // r = 2 (d.n) n - d, all aligned to three times the input fraction.
        prod  = dot2 * n2[i];
        r3[i] <= (prod <<< 1) - (R_W'(d2[i]) <<< (2 * IN_FRAC));
        neg4[i] <= r3[i][R_W-1];
        mag4[i] <= r3[i][R_W-1] ? MAG_W'(-r3[i]) : MAG_W'(r3[i]);
        mag5[i] <= mag4[i];
        // Bit length of the largest magnitude equals that of the OR.
        lz5[i] <= lz16(mag_or[i*CHUNK_W +: CHUNK_W]);
        nz5[i] <= |mag_or[i*CHUNK_W +: CHUNK_W];
        side6.a[i] <= NORM_W'((mag5[i] << lz6) >> (MAG_W - NORM_W));
        sq7[i] <= SQ_W'(side6.a[i]) * SQ_W'(side6.a[i]);
      end
      dot2 <= DOT_W'(p1[0]) + DOT_W'(p1[1]) + DOT_W'(p1[2]);
      neg5 <= neg4;
      side6.tag.neg   <= neg5;
      side6.tag.degen <= ~|nz5;
      side7 <= side6;
      sum   <= SUM_W'(sq7[0]) + SUM_W'(sq7[1]) + SUM_W'(sq7[2]);
      side  <= side7;
    end
  end

endmodule

// ===== rtl/core/rdan_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdan_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rdan_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          sum_valid,
  input  logic [rdan_pkg::SUM_W-1:0]    sum,
  input  rdan_pkg::rdan_side_t          sum_side,
  output logic                          root_valid,
  output logic [rdan_pkg::ROOT_W-1:0]   root,
  output rdan_pkg::rdan_side_t          root_side
);
  import rdan_pkg::*;

  logic              vs [ROOT_W+1];
  logic [ROOT_W-1:0] rt [ROOT_W+1];
  logic [SUM_W-1:0]  rm [ROOT_W];
  rdan_side_t        sd [ROOT_W+1];

  assign vs[0] = sum_valid;
  assign rt[0] = '0;
  assign rm[0] = sum;
  assign sd[0] = sum_side;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic [SUM_W+1:0] trial;
    logic             take;

    // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
    assign trial = ((SUM_W + 2)'(rt[j]) << (K + 1)) + ((SUM_W + 2)'(1) << (2 * K));
    assign take  = {2'b00, rm[j]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[j+1] <= take ? (rt[j] | (ROOT_W'(1) << K)) : rt[j];
        sd[j+1] <= sd[j];
      end
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rm[j+1] <= take ? (rm[j] - trial[SUM_W-1:0]) : rm[j];
        end
      end
    end
  end

  assign root_valid = vs[ROOT_W];
  assign root       = rt[ROOT_W];
  assign root_side  = sd[ROOT_W];

endmodule

// ===== rtl/core/rdan_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdan_div
// Three pipelined restoring dividers that scale the magnitudes by 1/length.
// ----------------------------------------------------------------------------
module rdan_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              root_valid,
  input  logic [rdan_pkg::ROOT_W-1:0]       root,
  input  rdan_pkg::rdan_side_t              root_side,
  output logic                              q_valid,
  output logic [2:0][rdan_pkg::Q_W-1:0]     q,
  output rdan_pkg::rdan_tag_t               q_tag
);
  import rdan_pkg::*;

  logic                      vs [Q_W+1];
  logic [ROOT_W-1:0]         len [Q_W+1];
  logic [2:0][NUM_W-1:0]     rm [Q_W];
  logic [2:0][Q_W-1:0]       qq [Q_W+1];
  rdan_tag_t                 tg [Q_W+1];

  // Numerator with half the divisor added gives rounding to nearest.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rm[0][i] <= (NUM_W'(root_side.a[i]) << OUT_FRAC) + NUM_W'(root >> 1);
      end
      len[0] <= root;
      qq[0]  <= '0;
      tg[0]  <= root_side.tag;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int K = Q_W - 1 - j;
    logic [NUM_W:0] dv;
    logic [2:0]     take;

    assign dv = (NUM_W + 1)'(len[j]) << K;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      assign take[i] = {1'b0, rm[j][i]} >= dv;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j+1] <= 1'b0;
      end else if (en) begin
        vs[j+1] <= vs[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          qq[j+1][i] <= take[i] ? (qq[j][i] | (Q_W'(1) << K)) : qq[j][i];
        end
        len[j+1] <= len[j];
        tg[j+1]  <= tg[j];
      end
    end

    if (j < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            rm[j+1][i] <= take[i] ? (rm[j][i] - dv[NUM_W-1:0]) : rm[j][i];
          end
        end
      end
    end
  end

  assign q_valid = vs[Q_W];
  assign q       = qq[Q_W];
  assign q_tag   = tg[Q_W];

endmodule
